FILE: rtl/core/coo_rows_to_ragged_row_splits_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the row-split converter
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COO_ROWS_TO_RAGGED_ROW_SPLITS_TOP_MACROS_SVH
`define COO_ROWS_TO_RAGGED_ROW_SPLITS_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define CRR_NEVER(label, cond, msg) \
    `CRR_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/core/coo_rrs_pkg.sv
// ----------------------------------------------------------------------------
// Row-split converter package
// Constants, configuration codes and the records passed between the stages.
// ----------------------------------------------------------------------------
package coo_rrs_pkg;

    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int SPLIT_W = 17;
    localparam int CNT_W   = 21;
    localparam int PREV_W  = 18;

    localparam logic [SPLIT_W-1:0] MAX_ROWS    = 17'd65536;
    localparam logic [SPLIT_W-1:0] MAX_COLS    = 17'd65536;
    localparam logic [CNT_W-1:0]   MAX_ENTRIES = 21'd1048576;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 2'd0,
        CFG_NUM_COLS = 2'd1,
        CFG_VALIDATE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SPLIT_W-1:0] row_limit;
        logic [SPLIT_W-1:0] col_limit;
        logic               validate;
    } t_cfg;

    typedef struct packed {
        logic               fill_valid;
        logic [SPLIT_W-1:0] fill_first;
        logic [SPLIT_W-1:0] fill_last;
        logic [CNT_W-1:0]   fill_value;
        logic               error;
        logic               last_of_run;
    } t_result;

    // One queued command: the entry result, and the closing result when
    // has_close is set.
    typedef struct packed {
        t_result ent;
        logic    has_close;
        t_result cls;
    } t_cmd;

endpackage

FILE: rtl/core/coo_rrs_front.sv
// ----------------------------------------------------------------------------
// Row-split converter front end
// Holds the per-set state, validates each entry and builds its commands.
// ----------------------------------------------------------------------------
module coo_rrs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  coo_rrs_pkg::t_cfg                   i_cfg,
    input  logic                                i_accept,
    input  logic [coo_rrs_pkg::ROW_W-1:0]       i_row_index,
    input  logic [coo_rrs_pkg::COL_W-1:0]       i_col_index,
    input  logic                                i_is_final,
    output coo_rrs_pkg::t_cmd                   o_cmd
);

    logic [coo_rrs_pkg::PREV_W-1:0]  r_prior_row, n_prior_row;
    logic [coo_rrs_pkg::PREV_W-1:0]  r_prior_col, n_prior_col;
    logic [coo_rrs_pkg::CNT_W-1:0]   r_count,     n_count;
    logic                            r_err,       n_err;

    logic [coo_rrs_pkg::SPLIT_W-1:0] rows_eff;
    logic [coo_rrs_pkg::SPLIT_W-1:0] cols_eff;
    logic [coo_rrs_pkg::PREV_W-1:0]  row_ext;
    logic [coo_rrs_pkg::PREV_W-1:0]  col_ext;
    logic [coo_rrs_pkg::PREV_W-1:0]  exp_col;
    logic                            row_change;
    logic                            bad_row;
    logic                            bad_col;
    logic                            bad;
    logic                            ok;
    logic [coo_rrs_pkg::PREV_W-1:0]  ent_first;
    logic [coo_rrs_pkg::SPLIT_W-1:0] ent_last;
    logic                            ent_valid;
    logic [coo_rrs_pkg::PREV_W-1:0]  cls_first;
    logic                            cls_valid;

    always_comb begin
        rows_eff = (i_cfg.row_limit > coo_rrs_pkg::MAX_ROWS) ? coo_rrs_pkg::MAX_ROWS
                                                              : i_cfg.row_limit;
        cols_eff = (i_cfg.col_limit > coo_rrs_pkg::MAX_COLS) ? coo_rrs_pkg::MAX_COLS
                                                              : i_cfg.col_limit;
        row_ext = {2'b00, i_row_index};
        col_ext = {2'b00, i_col_index};

        // The previous row is minus one (all ones) at the start of a set,
        // and no row lies below it.
        row_change = (row_ext != r_prior_row);
        bad_row    = row_change &&
                     ((!r_prior_row[coo_rrs_pkg::PREV_W-1] && (row_ext < r_prior_row)) ||
                      ({1'b0, i_row_index} >= rows_eff));
        exp_col    = row_change ? '0 : r_prior_col + 1'b1;
        bad_col    = (col_ext != exp_col) || ({1'b0, i_col_index} >= cols_eff);

        bad = !r_err && ((r_count >= coo_rrs_pkg::MAX_ENTRIES) ||
                         (i_cfg.validate && (bad_row || bad_col)));
        ok  = !r_err && !bad;

        n_err       = r_err | bad;
        n_prior_row = ok ? row_ext : r_prior_row;
        n_prior_col = (ok && i_cfg.validate) ? col_ext : r_prior_col;
        n_count     = ok ? r_count + 1'b1 : r_count;

        ent_first = r_prior_row + 1'b1;
        ent_last  = ({1'b0, i_row_index} > rows_eff) ? rows_eff : {1'b0, i_row_index};
        ent_valid = ok && (ent_first <= {1'b0, ent_last});

        cls_first = n_prior_row + 1'b1;
        cls_valid = !n_err && (cls_first <= {1'b0, rows_eff});

        o_cmd.ent.fill_valid  = ent_valid;
        o_cmd.ent.fill_first  = ent_valid ? ent_first[coo_rrs_pkg::SPLIT_W-1:0] : '0;
        o_cmd.ent.fill_last   = ent_valid ? ent_last : '0;
        o_cmd.ent.fill_value  = ent_valid ? r_count : '0;
        o_cmd.ent.error       = 1'b0;
        o_cmd.ent.last_of_run = !i_is_final;

        o_cmd.has_close       = i_is_final;

        o_cmd.cls.fill_valid  = cls_valid;
        o_cmd.cls.fill_first  = cls_valid ? cls_first[coo_rrs_pkg::SPLIT_W-1:0] : '0;
        o_cmd.cls.fill_last   = cls_valid ? rows_eff : '0;
        o_cmd.cls.fill_value  = cls_valid ? n_count : '0;
        o_cmd.cls.error       = n_err;
        o_cmd.cls.last_of_run = 1'b1;
    end

    // A final entry returns the state to its start-of-set values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_row <= '1;
            r_prior_col <= '1;
            r_count     <= '0;
            r_err       <= 1'b0;
        end else if (i_accept) begin
            if (i_is_final) begin
                r_prior_row <= '1;
                r_prior_col <= '1;
                r_count     <= '0;
                r_err       <= 1'b0;
            end else begin
                r_prior_row <= n_prior_row;
                r_prior_col <= n_prior_col;
                r_count     <= n_count;
                r_err       <= n_err;
            end
        end
    end

endmodule

FILE: rtl/core/coo_rrs_fifo.sv
// ----------------------------------------------------------------------------
// Row-split converter command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "coo_rows_to_ragged_row_splits_top_macros.svh"

module coo_rrs_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  coo_rrs_pkg::t_cmd i_data,
    output logic              o_full,
    input  logic              i_pop,
    output coo_rrs_pkg::t_cmd o_data,
    output logic              o_empty
);

    coo_rrs_pkg::t_cmd                r_mem [coo_rrs_pkg::QUEUE_DEPTH];
    logic [coo_rrs_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [coo_rrs_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [coo_rrs_pkg::QCNT_W-1:0]   r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == coo_rrs_pkg::QCNT_W'(coo_rrs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == coo_rrs_pkg::QPTR_W'(coo_rrs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == coo_rrs_pkg::QPTR_W'(coo_rrs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CRR_NEVER(a_fifo_overfill, r_count > coo_rrs_pkg::QCNT_W'(coo_rrs_pkg::QUEUE_DEPTH), "queue count above depth")
    `CRR_ASSERT(a_fifo_ptr_gap, (o_empty || o_full) |-> (r_wr_ptr == r_rd_ptr), "queue pointers disagree with count")

endmodule

FILE: rtl/core/coo_rrs_back.sv
// ----------------------------------------------------------------------------
// Row-split converter back end
// Expands queued commands into one or two results through an output register.
// ----------------------------------------------------------------------------
`include "coo_rows_to_ragged_row_splits_top_macros.svh"

module coo_rrs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  coo_rrs_pkg::t_cmd    i_cmd,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output coo_rrs_pkg::t_result o_result
);

    logic                 r_out_valid;
    coo_rrs_pkg::t_result r_out;
    logic                 r_close_phase;
    logic                 load;

    // The output register takes a new result when it is empty or is being
    // drained in this cycle.
    assign load      = !i_cmd_empty && (!r_out_valid || i_pop);
    assign o_cmd_pop = load && (r_close_phase || !i_cmd.has_close);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_close_phase ? i_cmd.cls : i_cmd.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_close_phase <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_close_phase <= !r_close_phase && i_cmd.has_close;
            end
        end
    end

    `CRR_ASSERT(a_back_close_head, r_close_phase |-> (!i_cmd_empty && i_cmd.has_close), "closing phase without a closing command")
    `CRR_ASSERT(a_back_close_order, (load && r_close_phase) |=> (r_out.last_of_run && !r_close_phase), "closing result not last of its run")

endmodule

FILE: rtl/core/coo_rows_to_ragged_row_splits_top.sv
// ----------------------------------------------------------------------------
// Sparse row to ragged row-split converter
// Turns row-major sparse coordinates into row-split fill commands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  -------   ---------  -------------------  ---------------------------------------
//  entry     in         push / full          i_row_index, i_col_index, i_is_final
//  result    out        empty / pop          o_fill_valid .. o_last_of_run
//  config    in         i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
//  One entry transaction is taken every cycle while the four-deep command queue has room.
//  A non-final entry yields one result and a final entry two; results leave one per cycle
//  while pop is asserted. An accepted entry's command is written into the queue, and its first
//  result is then loaded from the queue head into the output register, from which it is popped.
//  Reset is synchronous and active low; it clears the set state, queue and output register.
//  A stalled result side fills the queue, and full then holds off new entries.
//
// ----------------------------------------------------------------------------
module coo_rows_to_ragged_row_splits_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   push,
    output logic                                   full,
    input  logic [coo_rrs_pkg::ROW_W-1:0]          i_row_index,
    input  logic [coo_rrs_pkg::COL_W-1:0]          i_col_index,
    input  logic                                   i_is_final,

    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   o_fill_valid,
    output logic [coo_rrs_pkg::SPLIT_W-1:0]        o_fill_first,
    output logic [coo_rrs_pkg::SPLIT_W-1:0]        o_fill_last,
    output logic [coo_rrs_pkg::CNT_W-1:0]          o_fill_value,
    output logic                                   o_error,
    output logic                                   o_last_of_run,

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [coo_rrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [coo_rrs_pkg::SPLIT_W-1:0]        i_cfg_data
);

    coo_rrs_pkg::t_cfg    r_cfg;
    coo_rrs_pkg::t_cmd    front_cmd;
    coo_rrs_pkg::t_cmd    queue_head;
    coo_rrs_pkg::t_result result;
    logic                 accept;
    logic                 queue_empty;
    logic                 queue_pop;

    // Register writes are always taken; the write index selects the register
    // and an index past the list is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_limit <= coo_rrs_pkg::SPLIT_W'(1);
            r_cfg.col_limit <= coo_rrs_pkg::SPLIT_W'(1);
            r_cfg.validate  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                coo_rrs_pkg::CFG_NUM_ROWS: r_cfg.row_limit <= i_cfg_data;
                coo_rrs_pkg::CFG_NUM_COLS: r_cfg.col_limit <= i_cfg_data;
                coo_rrs_pkg::CFG_VALIDATE: r_cfg.validate  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The front end updates its set state at the same edge that the command
    // enters the queue.
    assign accept = push && !full;

    coo_rrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_is_final  (i_is_final),
        .o_cmd       (front_cmd)
    );

    coo_rrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_data  (queue_head),
        .o_empty (queue_empty)
    );

    coo_rrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_head),
        .i_cmd_empty (queue_empty),
        .o_cmd_pop   (queue_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_fill_valid  = result.fill_valid;
    assign o_fill_first  = result.fill_first;
    assign o_fill_last   = result.fill_last;
    assign o_fill_value  = result.fill_value;
    assign o_error       = result.error;
    assign o_last_of_run = result.last_of_run;

endmodule
